/* src/qcr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcr_pkg
// Shared widths, codes, record types and helper functions of the quad
// corner rotator.
// ----------------------------------------------------------------------------
package qcr_pkg;

    // Field widths
    localparam int COORD_WIDTH   = 24;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int TEX_W         = 16;
    localparam int COLOR_W       = 32;

    // Sine / cosine format: Q2.30 in 32 bits
    localparam int TRIG_W    = 32;
    localparam int TRIG_FRAC = 30;

    localparam int STAGE_IDX_W = $clog2(CORDIC_STAGES);

    // Corner offset, product and sum widths
    localparam int DELTA_W = COORD_WIDTH + 2;
    localparam int PROD_W  = DELTA_W + TRIG_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int RES_W   = SUM_W - TRIG_FRAC;

    localparam logic signed [TRIG_W-1:0] CORDIC_K = 32'sd652032875;

    // Input tdata layout, lowest field first
    localparam int OFF_CX    = 0;
    localparam int OFF_CY    = OFF_CX + COORD_WIDTH;
    localparam int OFF_HW    = OFF_CY + COORD_WIDTH;
    localparam int OFF_HH    = OFF_HW + COORD_WIDTH - 1;
    localparam int OFF_PX    = OFF_HH + COORD_WIDTH - 1;
    localparam int OFF_PY    = OFF_PX + COORD_WIDTH;
    localparam int OFF_ANG   = OFF_PY + COORD_WIDTH;
    localparam int OFF_COL   = OFF_ANG + ANGLE_WIDTH;
    localparam int OFF_TU    = OFF_COL + COLOR_W;
    localparam int OFF_TV    = OFF_TU + TEX_W;
    localparam int OFF_SU    = OFF_TV + TEX_W;
    localparam int OFF_SV    = OFF_SU + TEX_W;
    localparam int IN_BITS   = OFF_SV + TEX_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout
    localparam int OUT_BITS    = 2 * COORD_WIDTH + COLOR_W + 2 * TEX_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Quadrant codes from the top two angle bits
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef enum logic [1:0] {
        CORNER_TL = 2'd0,
        CORNER_TR = 2'd1,
        CORNER_BR = 2'd2,
        CORNER_BL = 2'd3
    } t_corner_id;

    // Rotator vector and residual angle
    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [TRIG_W-1:0] z;
    } t_rot;

    // Per-quad data that rides along the rotator chain
    typedef struct packed {
        logic [1:0]                    quad;
        logic signed [COORD_WIDTH:0]   base_dx;
        logic signed [COORD_WIDTH:0]   base_dy;
        logic [COORD_WIDTH-2:0]        half_w;
        logic [COORD_WIDTH-2:0]        half_h;
        logic signed [COORD_WIDTH-1:0] pivot_x;
        logic signed [COORD_WIDTH-1:0] pivot_y;
        logic [COLOR_W-1:0]            color;
        logic signed [TEX_W-1:0]       tex_u;
        logic signed [TEX_W-1:0]       tex_v;
        logic signed [TEX_W-1:0]       span_u;
        logic signed [TEX_W-1:0]       span_v;
    } t_quad_data;

    // One corner on its way to the multipliers
    typedef struct packed {
        t_corner_id                    corner;
        logic                          last;
        logic signed [DELTA_W-1:0]     dx;
        logic signed [DELTA_W-1:0]     dy;
        logic signed [TRIG_W-1:0]      cos_v;
        logic signed [TRIG_W-1:0]      sin_v;
        logic signed [COORD_WIDTH-1:0] pivot_x;
        logic signed [COORD_WIDTH-1:0] pivot_y;
        logic [COLOR_W-1:0]            color;
        logic signed [TEX_W-1:0]       u;
        logic signed [TEX_W-1:0]       v;
    } t_corner;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [TRIG_W-1:0] atan_turn(input int idx);
        logic signed [TRIG_W-1:0] a;
        case (idx)
            0:       a = 32'sd536870912;
            1:       a = 32'sd316933406;
            2:       a = 32'sd167458907;
            3:       a = 32'sd85004757;
            4:       a = 32'sd42667331;
            5:       a = 32'sd21354465;
            6:       a = 32'sd10679838;
            7:       a = 32'sd5340245;
            8:       a = 32'sd2670163;
            9:       a = 32'sd1335087;
            10:      a = 32'sd667544;
            11:      a = 32'sd333772;
            12:      a = 32'sd166886;
            13:      a = 32'sd83443;
            14:      a = 32'sd41722;
            15:      a = 32'sd20861;
            16:      a = 32'sd10430;
            17:      a = 32'sd5215;
            18:      a = 32'sd2608;
            19:      a = 32'sd1304;
            20:      a = 32'sd652;
            21:      a = 32'sd326;
            22:      a = 32'sd163;
            23:      a = 32'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Clamp a one-bit-wider texture sum to the texture range
    function automatic logic signed [TEX_W-1:0] sat_tex(input logic signed [TEX_W:0] v);
        logic signed [TEX_W-1:0] r;
        if (v[TEX_W] != v[TEX_W-1]) begin
            r = v[TEX_W] ? {1'b1, {(TEX_W-1){1'b0}}} : {1'b0, {(TEX_W-1){1'b1}}};
        end else begin
            r = v[TEX_W-1:0];
        end
        return r;
    endfunction

    // Clamp a rounded coordinate to the coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [RES_W-1:0] v
    );
        logic [RES_W-COORD_WIDTH:0] upper;
        logic signed [COORD_WIDTH-1:0] r;
        upper = v[RES_W-1:COORD_WIDTH-1];
        if ((&upper) || !(|upper)) begin
            r = v[COORD_WIDTH-1:0];
        end else if (v[RES_W-1]) begin
            r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

/* src/qcr_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcr_cordic_cell
// One micro-rotation of the sine/cosine chain. Holds one quad's vector,
// residual angle and payload, and hands them to the next cell.
// ----------------------------------------------------------------------------
module qcr_cordic_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic [qcr_pkg::STAGE_IDX_W-1:0]      i_shift,
    input  logic signed [qcr_pkg::TRIG_W-1:0]    i_atan,
    input  logic                                 i_valid,
    input  qcr_pkg::t_rot                        i_rot,
    input  qcr_pkg::t_quad_data                  i_data,
    output logic                                 o_valid,
    output qcr_pkg::t_rot                        o_rot,
    output qcr_pkg::t_quad_data                  o_data
);
    import qcr_pkg::*;

    logic                     r_valid;
    t_rot                     r_rot;
    t_rot                     n_rot;
    t_quad_data               r_data;
    logic signed [TRIG_W-1:0] x_sh;
    logic signed [TRIG_W-1:0] y_sh;

    // Floor shifts of the incoming vector
    assign x_sh = $signed(i_rot.x) >>> i_shift;
    assign y_sh = $signed(i_rot.y) >>> i_shift;

    // Rotate toward zero residual
    always_comb begin
        if (!i_rot.z[TRIG_W-1]) begin
            n_rot.x = i_rot.x - y_sh;
            n_rot.y = i_rot.y + x_sh;
            n_rot.z = i_rot.z - i_atan;
        end else begin
            n_rot.x = i_rot.x + y_sh;
            n_rot.y = i_rot.y - x_sh;
            n_rot.z = i_rot.z + i_atan;
        end
    end

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot  <= n_rot;
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;
    assign o_data  = r_data;

endmodule

/* src/qcr_corner_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcr_corner_seq
// Takes one quad from the end of the chain, fixes the quadrant of sine and
// cosine, issues its four corners (offsets, texture) one per i_advance cycle.
// ----------------------------------------------------------------------------
module qcr_corner_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic                 i_valid,
    input  qcr_pkg::t_rot        i_rot,
    input  qcr_pkg::t_quad_data  i_data,
    output logic                 o_take,
    output logic                 o_valid,
    output qcr_pkg::t_corner     o_corner
);
    import qcr_pkg::*;

    logic                          r_have;
    t_corner_id                    r_cnt;
    t_quad_data                    r_data;
    logic signed [TRIG_W-1:0]      r_cos;
    logic signed [TRIG_W-1:0]      r_sin;
    logic signed [TRIG_W-1:0]      n_cos;
    logic signed [TRIG_W-1:0]      n_sin;
    logic                          r_p1_valid;
    t_corner                       r_p1;
    t_corner                       n_p1;
    logic                          is_right;
    logic                          is_bottom;
    logic signed [DELTA_W-1:0]     base_dx;
    logic signed [DELTA_W-1:0]     base_dy;
    logic signed [DELTA_W-1:0]     half_w;
    logic signed [DELTA_W-1:0]     half_h;
    logic signed [TEX_W:0]         u_sum;
    logic signed [TEX_W:0]         v_sum;

    assign o_take = !r_have || ((r_cnt == CORNER_BL) && i_advance);

    // Turn the chain result into the right quadrant
    always_comb begin
        case (i_data.quad)
            QUAD_0: begin
                n_cos = i_rot.x;
                n_sin = i_rot.y;
            end
            QUAD_1: begin
                n_cos = -i_rot.y;
                n_sin = i_rot.x;
            end
            QUAD_2: begin
                n_cos = -i_rot.x;
                n_sin = -i_rot.y;
            end
            QUAD_3: begin
                n_cos = i_rot.y;
                n_sin = -i_rot.x;
            end
            default: begin
                n_cos = i_rot.x;
                n_sin = i_rot.y;
            end
        endcase
    end

    // Corner offsets and texture coordinates for the current corner
    always_comb begin
        is_right  = r_cnt inside {CORNER_TR, CORNER_BR};
        is_bottom = r_cnt inside {CORNER_BR, CORNER_BL};
        base_dx   = DELTA_W'(r_data.base_dx);
        base_dy   = DELTA_W'(r_data.base_dy);
        half_w    = $signed(DELTA_W'(r_data.half_w));
        half_h    = $signed(DELTA_W'(r_data.half_h));
        u_sum     = (TEX_W+1)'(r_data.tex_u)
                  + (is_right ? (TEX_W+1)'(r_data.span_u) : '0);
        v_sum     = (TEX_W+1)'(r_data.tex_v)
                  + (is_bottom ? (TEX_W+1)'(r_data.span_v) : '0);

        n_p1.corner  = r_cnt;
        n_p1.last    = (r_cnt == CORNER_BL);
        n_p1.dx      = is_right  ? base_dx + half_w : base_dx - half_w;
        n_p1.dy      = is_bottom ? base_dy + half_h : base_dy - half_h;
        n_p1.cos_v   = r_cos;
        n_p1.sin_v   = r_sin;
        n_p1.pivot_x = r_data.pivot_x;
        n_p1.pivot_y = r_data.pivot_y;
        n_p1.color   = r_data.color;
        n_p1.u       = sat_tex(u_sum);
        n_p1.v       = sat_tex(v_sum);
    end

    // Corner counter and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_cnt      <= CORNER_TL;
            r_p1_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_have <= i_valid;
                r_cnt  <= CORNER_TL;
            end else if (i_advance) begin
                r_cnt <= t_corner_id'(r_cnt + 2'd1);
            end
            if (i_advance) begin
                r_p1_valid <= r_have;
            end
        end
    end

    // Held quad and corner register
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_data <= i_data;
            r_cos  <= n_cos;
            r_sin  <= n_sin;
        end
        if (i_advance) begin
            r_p1 <= n_p1;
        end
    end

    assign o_valid  = r_p1_valid;
    assign o_corner = r_p1;

endmodule

/* src/qcr_corner_math.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcr_corner_math
// Multiplies one corner's offsets by sine and cosine, then rounds, adds the
// pivot and clamps into the output register.
// ----------------------------------------------------------------------------
module qcr_corner_math (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_out_ready,
    input  logic                                  i_valid,
    input  qcr_pkg::t_corner                      i_corner,
    output logic                                  o_advance,
    output logic                                  o_valid,
    output logic signed [qcr_pkg::COORD_WIDTH-1:0] o_x,
    output logic signed [qcr_pkg::COORD_WIDTH-1:0] o_y,
    output logic [qcr_pkg::COLOR_W-1:0]           o_color,
    output logic signed [qcr_pkg::TEX_W-1:0]      o_u,
    output logic signed [qcr_pkg::TEX_W-1:0]      o_v,
    output qcr_pkg::t_corner_id                   o_corner,
    output logic                                  o_last
);
    import qcr_pkg::*;

    localparam logic signed [SUM_W-1:0] ROUND_TERM = SUM_W'(1) <<< (TRIG_FRAC - 1);

    // Product stage
    logic                          r_p2_valid;
    logic signed [PROD_W-1:0]      r_dxc;
    logic signed [PROD_W-1:0]      r_dys;
    logic signed [PROD_W-1:0]      r_dyc;
    logic signed [PROD_W-1:0]      r_dxs;
    t_corner                       r_p2;

    // Output stage
    logic                          r_out_valid;
    logic signed [COORD_WIDTH-1:0] r_x;
    logic signed [COORD_WIDTH-1:0] r_y;
    logic [COLOR_W-1:0]            r_color;
    logic signed [TEX_W-1:0]       r_u;
    logic signed [TEX_W-1:0]       r_v;
    t_corner_id                    r_corner;
    logic                          r_last;

    logic signed [PROD_W-1:0]      n_dxc;
    logic signed [PROD_W-1:0]      n_dys;
    logic signed [PROD_W-1:0]      n_dyc;
    logic signed [PROD_W-1:0]      n_dxs;
    logic signed [SUM_W-1:0]       sum_x;
    logic signed [SUM_W-1:0]       sum_y;
    logic signed [RES_W-1:0]       res_x;
    logic signed [RES_W-1:0]       res_y;

    assign o_advance = !r_out_valid || i_out_ready;

    // Four products per corner
    assign n_dxc = $signed(i_corner.dx) * $signed(i_corner.cos_v);
    assign n_dys = $signed(i_corner.dy) * $signed(i_corner.sin_v);
    assign n_dyc = $signed(i_corner.dy) * $signed(i_corner.cos_v);
    assign n_dxs = $signed(i_corner.dx) * $signed(i_corner.sin_v);

    // Round half up; the pivot goes in at the binary point
    always_comb begin
        sum_x = SUM_W'(r_dxc) + SUM_W'(r_dys)
              + (SUM_W'($signed(r_p2.pivot_x)) <<< TRIG_FRAC) + ROUND_TERM;
        sum_y = SUM_W'(r_dyc) - SUM_W'(r_dxs)
              + (SUM_W'($signed(r_p2.pivot_y)) <<< TRIG_FRAC) + ROUND_TERM;
        res_x = $signed(sum_x[SUM_W-1:TRIG_FRAC]);
        res_y = $signed(sum_y[SUM_W-1:TRIG_FRAC]);
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_p2_valid  <= i_valid;
            r_out_valid <= r_p2_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_dxc    <= n_dxc;
            r_dys    <= n_dys;
            r_dyc    <= n_dyc;
            r_dxs    <= n_dxs;
            r_p2     <= i_corner;
            r_x      <= sat_coord(res_x);
            r_y      <= sat_coord(res_y);
            r_color  <= r_p2.color;
            r_u      <= r_p2.u;
            r_v      <= r_p2.v;
            r_corner <= r_p2.corner;
            r_last   <= r_p2.last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_color  = r_color;
    assign o_u      = r_u;
    assign o_v      = r_v;
    assign o_corner = r_corner;
    assign o_last   = r_last;

endmodule

/* src/quad_corner_rotator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_corner_rotator
// Rotates the four corners of a rectangle about a pivot by the negated
// angle and streams them out top left, top right, bottom right, bottom left.
// ----------------------------------------------------------------------------
// Each accepted request yields four corner requests on the output, one per
// cycle while the output is not stalled; the corner sequencer owns the single
// output channel, and one set of four multipliers serves all corners. Sine
// and cosine come from a chain of 16 CORDIC cells, one micro-rotation each,
// so several quads are in flight at once. Between input accept and the first
// corner lie the 16 chain cells, the sequencer hold register, the corner
// register, the product register and the output register. A stalled output
// holds the sequencer and the multiply stages; the chain keeps moving while
// its tail is empty and then holds as well. s_axis_tready follows
// m_axis_tready combinationally through the sequencer's take logic.
// ----------------------------------------------------------------------------
module quad_corner_rotator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // center_x, center_y, half_width, half_height, pivot_x, pivot_y, angle,
    // color, tex_u, tex_v, tex_u_span, tex_v_span, zero pad
    input  logic [qcr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // out_x, out_y, out_color, out_u, out_v
    output logic [qcr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // corner
    output logic [1:0]                         m_axis_tuser,
    output logic                               m_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready
);
    import qcr_pkg::*;

    logic       c_valid [0:CORDIC_STAGES];
    t_rot       c_rot   [0:CORDIC_STAGES];
    t_quad_data c_data  [0:CORDIC_STAGES];

    logic                          chain_en;
    logic                          seq_take;
    logic                          seq_valid;
    t_corner                       seq_corner;
    logic                          post_advance;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic [ANGLE_WIDTH-1:0]        ang;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic [COLOR_W-1:0]            out_color;
    logic signed [TEX_W-1:0]       out_u;
    logic signed [TEX_W-1:0]       out_v;
    t_corner_id                    out_corner;

    // Unpack the request and seed the chain
    always_comb begin
        cx  = $signed(s_axis_tdata[OFF_CX +: COORD_WIDTH]);
        cy  = $signed(s_axis_tdata[OFF_CY +: COORD_WIDTH]);
        ang = s_axis_tdata[OFF_ANG +: ANGLE_WIDTH];

        c_data[0].pivot_x = $signed(s_axis_tdata[OFF_PX +: COORD_WIDTH]);
        c_data[0].pivot_y = $signed(s_axis_tdata[OFF_PY +: COORD_WIDTH]);
        c_data[0].quad    = ang[ANGLE_WIDTH-1 -: 2];
        c_data[0].base_dx = (COORD_WIDTH+1)'(cx)
                          - (COORD_WIDTH+1)'(c_data[0].pivot_x);
        c_data[0].base_dy = (COORD_WIDTH+1)'(cy)
                          - (COORD_WIDTH+1)'(c_data[0].pivot_y);
        c_data[0].half_w  = s_axis_tdata[OFF_HW +: COORD_WIDTH-1];
        c_data[0].half_h  = s_axis_tdata[OFF_HH +: COORD_WIDTH-1];
        c_data[0].color   = s_axis_tdata[OFF_COL +: COLOR_W];
        c_data[0].tex_u   = $signed(s_axis_tdata[OFF_TU +: TEX_W]);
        c_data[0].tex_v   = $signed(s_axis_tdata[OFF_TV +: TEX_W]);
        c_data[0].span_u  = $signed(s_axis_tdata[OFF_SU +: TEX_W]);
        c_data[0].span_v  = $signed(s_axis_tdata[OFF_SV +: TEX_W]);

        c_rot[0].x = CORDIC_K;
        c_rot[0].y = '0;
        c_rot[0].z = $signed({2'b00, ang[ANGLE_WIDTH-3:0],
                              {(TRIG_W-ANGLE_WIDTH){1'b0}}});
        c_valid[0] = s_axis_tvalid;
    end

    // Chain moves whenever its tail is empty or the sequencer takes it
    assign chain_en      = seq_take || !c_valid[CORDIC_STAGES];
    assign s_axis_tready = chain_en;

    // CORDIC chain
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        qcr_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (chain_en),
            .i_shift (STAGE_IDX_W'(g)),
            .i_atan  (atan_turn(g)),
            .i_valid (c_valid[g]),
            .i_rot   (c_rot[g]),
            .i_data  (c_data[g]),
            .o_valid (c_valid[g+1]),
            .o_rot   (c_rot[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    // Corner sequencer
    qcr_corner_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (post_advance),
        .i_valid   (c_valid[CORDIC_STAGES]),
        .i_rot     (c_rot[CORDIC_STAGES]),
        .i_data    (c_data[CORDIC_STAGES]),
        .o_take    (seq_take),
        .o_valid   (seq_valid),
        .o_corner  (seq_corner)
    );

    // Multiply, round, clamp and output register
    qcr_corner_math u_math (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_out_ready (m_axis_tready),
        .i_valid     (seq_valid),
        .i_corner    (seq_corner),
        .o_advance   (post_advance),
        .o_valid     (m_axis_tvalid),
        .o_x         (out_x),
        .o_y         (out_y),
        .o_color     (out_color),
        .o_u         (out_u),
        .o_v         (out_v),
        .o_corner    (out_corner),
        .o_last      (m_axis_tlast)
    );

    // Output packing
    assign m_axis_tdata = OUT_TDATA_W'({out_v, out_u, out_color, out_y, out_x});
    assign m_axis_tuser = out_corner;

    // Corners of a quad leave back to back in order
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && (m_axis_tuser != CORNER_BL))
        |=> (m_axis_tvalid && (m_axis_tuser == 2'($past(m_axis_tuser) + 2'd1))))
        else $error("corner sequence broken");

    // Last flag marks the bottom left corner only
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == CORNER_BL)))
        else $error("tlast does not match corner");

    // Nothing is offered right after reset
    assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid straight out of reset");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quad_corner_rotator. Each accepted quad request is
// turned into four expected corners by a bit-exact CORDIC-based predictor;
// every corner that leaves the block is compared field by field with the
// oldest expectation. Stimulus is a directed set (quadrant angles,
// saturation, degenerate and texture overflow cases) followed by random
// quads, with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module tb;
    import qcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_QUADS   = 140;
    localparam int CALM_QUADS     = 30;
    localparam int DRAIN_CYCLES   = 40;

    // One quad request as driven on the input stream
    typedef struct {
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic [COORD_WIDTH-2:0]        hw;
        logic [COORD_WIDTH-2:0]        hh;
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
        logic [ANGLE_WIDTH-1:0]        angle;
        logic [COLOR_W-1:0]            color;
        logic signed [TEX_W-1:0]       tu;
        logic signed [TEX_W-1:0]       tv;
        logic signed [TEX_W-1:0]       su;
        logic signed [TEX_W-1:0]       sv;
    } quad_req_t;

    // One corner as expected on the output stream
    typedef struct {
        t_corner_id                    corner;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic [COLOR_W-1:0]            color;
        logic signed [TEX_W-1:0]       u;
        logic signed [TEX_W-1:0]       v;
        logic                          last;
    } corner_t;

    // ------------------------------------------------------------------------
    // Corner predictor and scoreboard
    // ------------------------------------------------------------------------
    class corner_scoreboard;
        corner_t pending[$];
        int      errors;

        // Arctangent of 2^-i, units of 2^-32 turn
        longint atan_lut[24] = '{
            536870912, 316933406, 167458907, 85004757,
            42667331, 21354465, 10679838, 5340245,
            2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861,
            10430, 5215, 2608, 1304,
            652, 326, 163, 81
        };

        function new();
            errors = 0;
        endfunction

        static function longint clamp(longint v, int w);
            longint hi;
            hi = (longint'(1) <<< (w - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        // Q2.30 cosine and sine of the angle, folded by quadrant
        function void cos_sin(input logic [ANGLE_WIDTH-1:0] angle,
                              output longint c, output longint s);
            logic [31:0] phase;
            logic [1:0]  quad;
            longint      x, y, z, xs, ys;
            phase = 32'(angle) << (32 - ANGLE_WIDTH);
            quad  = phase[31:30];
            z     = longint'(phase[29:0]);
            x     = longint'(CORDIC_K);
            y     = 0;
            for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z = z - atan_lut[i];
                end else begin
                    x = x + ys; y = y - xs; z = z + atan_lut[i];
                end
            end
            case (quad)
                QUAD_0: begin c = x;  s = y;  end
                QUAD_1: begin c = -y; s = x;  end
                QUAD_2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        // Accepted quad: queue its four corners
        function void note_request(input logic [IN_TDATA_W-1:0] d);
            logic signed [COORD_WIDTH-1:0] f_cx, f_cy, f_px, f_py;
            logic signed [TEX_W-1:0]       f_tu, f_tv, f_su, f_sv;
            longint  cx, cy, hw, hh, px, py, c, s, dx, dy, rx, ry, u, v;
            corner_t e;
            f_cx = d[OFF_CX +: COORD_WIDTH];
            f_cy = d[OFF_CY +: COORD_WIDTH];
            f_px = d[OFF_PX +: COORD_WIDTH];
            f_py = d[OFF_PY +: COORD_WIDTH];
            f_tu = d[OFF_TU +: TEX_W];
            f_tv = d[OFF_TV +: TEX_W];
            f_su = d[OFF_SU +: TEX_W];
            f_sv = d[OFF_SV +: TEX_W];
            cx = f_cx; cy = f_cy; px = f_px; py = f_py;
            hw = longint'(d[OFF_HW +: COORD_WIDTH-1]);
            hh = longint'(d[OFF_HH +: COORD_WIDTH-1]);
            cos_sin(d[OFF_ANG +: ANGLE_WIDTH], c, s);
            for (int k = 0; k < 4; k++) begin
                e.corner = t_corner_id'(k);
                dx = (e.corner == CORNER_TL || e.corner == CORNER_BL) ? cx - hw : cx + hw;
                dy = (e.corner == CORNER_TL || e.corner == CORNER_TR) ? cy - hh : cy + hh;
                dx = dx - px;
                dy = dy - py;
                rx = ((dx * c + dy * s + (longint'(1) <<< 29)) >>> 30) + px;
                ry = ((dy * c - dx * s + (longint'(1) <<< 29)) >>> 30) + py;
                u  = longint'(f_tu);
                v  = longint'(f_tv);
                if (e.corner == CORNER_TR || e.corner == CORNER_BR) u = u + f_su;
                if (e.corner == CORNER_BR || e.corner == CORNER_BL) v = v + f_sv;
                e.x     = COORD_WIDTH'(clamp(rx, COORD_WIDTH));
                e.y     = COORD_WIDTH'(clamp(ry, COORD_WIDTH));
                e.color = d[OFF_COL +: COLOR_W];
                e.u     = TEX_W'(clamp(u, TEX_W));
                e.v     = TEX_W'(clamp(v, TEX_W));
                e.last  = (e.corner == CORNER_BL);
                pending.push_back(e);
            end
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Accepted corner: compare with the oldest expectation
        task check_corner(input corner_t got);
            corner_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected corner %0d", got.corner));
                return;
            end
            e = pending.pop_front();
            if (got.corner !== e.corner)
                report($sformatf("corner %0d, expected %0d", got.corner, e.corner));
            if (got.x !== e.x)
                report($sformatf("corner %0d x %0d, expected %0d", e.corner, got.x, e.x));
            if (got.y !== e.y)
                report($sformatf("corner %0d y %0d, expected %0d", e.corner, got.y, e.y));
            if (got.color !== e.color)
                report($sformatf("corner %0d color %h, expected %h",
                                 e.corner, got.color, e.color));
            if (got.u !== e.u)
                report($sformatf("corner %0d u %0d, expected %0d", e.corner, got.u, e.u));
            if (got.v !== e.v)
                report($sformatf("corner %0d v %0d, expected %0d", e.corner, got.v, e.v));
            if (got.last !== e.last)
                report($sformatf("corner %0d last %b, expected %b",
                                 e.corner, got.last, e.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT
    // ------------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;

    logic                   calm;
    int                     stall_left;
    int                     quiet_cycles;
    corner_scoreboard       sb;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    quad_corner_rotator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // ------------------------------------------------------------------------
    // Monitors: record accepted requests and check corners
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tdata);
    end

    always @(posedge i_clk) begin
        corner_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.corner = t_corner_id'(m_axis_tuser);
            got.x      = m_axis_tdata[0 +: COORD_WIDTH];
            got.y      = m_axis_tdata[COORD_WIDTH +: COORD_WIDTH];
            got.color  = m_axis_tdata[2*COORD_WIDTH +: COLOR_W];
            got.u      = m_axis_tdata[2*COORD_WIDTH + COLOR_W +: TEX_W];
            got.v      = m_axis_tdata[2*COORD_WIDTH + COLOR_W + TEX_W +: TEX_W];
            got.last   = m_axis_tlast;
            sb.check_corner(got);
        end
    end

    // Receiver: random stall bursts, none once calm
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if ($urandom_range(4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 9);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted request on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic quad_req_t make_quad(
        input int cx, input int cy, input int hw, input int hh,
        input int px, input int py, input int angle, input logic [31:0] color,
        input int tu, input int tv, input int su, input int sv
    );
        quad_req_t r;
        r.cx = COORD_WIDTH'(cx); r.cy = COORD_WIDTH'(cy);
        r.hw = (COORD_WIDTH-1)'(hw); r.hh = (COORD_WIDTH-1)'(hh);
        r.px = COORD_WIDTH'(px); r.py = COORD_WIDTH'(py);
        r.angle = ANGLE_WIDTH'(angle); r.color = color;
        r.tu = TEX_W'(tu); r.tv = TEX_W'(tv); r.su = TEX_W'(su); r.sv = TEX_W'(sv);
        return r;
    endfunction

    // Mostly mid-range geometry, some fully random fields
    function automatic quad_req_t random_quad();
        quad_req_t r;
        if ($urandom_range(4) == 0) begin
            r.cx = COORD_WIDTH'($urandom); r.cy = COORD_WIDTH'($urandom);
            r.hw = (COORD_WIDTH-1)'($urandom); r.hh = (COORD_WIDTH-1)'($urandom);
            r.px = COORD_WIDTH'($urandom); r.py = COORD_WIDTH'($urandom);
        end else begin
            r.cx = COORD_WIDTH'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            r.cy = COORD_WIDTH'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            r.hw = (COORD_WIDTH-1)'($urandom_range(0, 1 << 18));
            r.hh = (COORD_WIDTH-1)'($urandom_range(0, 1 << 18));
            r.px = COORD_WIDTH'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            r.py = COORD_WIDTH'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        end
        // rotation about the center
        if ($urandom_range(2) == 0) begin
            r.px = r.cx;
            r.py = r.cy;
        end
        r.angle = ANGLE_WIDTH'($urandom);
        r.color = $urandom;
        r.tu = TEX_W'($urandom); r.tv = TEX_W'($urandom);
        r.su = TEX_W'($urandom); r.sv = TEX_W'($urandom);
        return r;
    endfunction

    task automatic send_quad(input quad_req_t r);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[OFF_CX +: COORD_WIDTH]    = r.cx;
        d[OFF_CY +: COORD_WIDTH]    = r.cy;
        d[OFF_HW +: COORD_WIDTH-1]  = r.hw;
        d[OFF_HH +: COORD_WIDTH-1]  = r.hh;
        d[OFF_PX +: COORD_WIDTH]    = r.px;
        d[OFF_PY +: COORD_WIDTH]    = r.py;
        d[OFF_ANG +: ANGLE_WIDTH]   = r.angle;
        d[OFF_COL +: COLOR_W]       = r.color;
        d[OFF_TU +: TEX_W]          = r.tu;
        d[OFF_TV +: TEX_W]          = r.tv;
        d[OFF_SU +: TEX_W]          = r.su;
        d[OFF_SV +: TEX_W]          = r.sv;
        // idle burst before the request
        if (!calm && $urandom_range(3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    initial begin
        quad_req_t dir[$];
        int        cmax, cmin, hmax, rect_x, rect_y;
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        calm          <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cmax   = (1 << (COORD_WIDTH - 1)) - 1;
        cmin   = -(1 << (COORD_WIDTH - 1));
        hmax   = (1 << (COORD_WIDTH - 1)) - 1;
        rect_x = 100 * 256;
        rect_y = 50 * 256;

        // all zero, then the quadrant boundaries about the center
        dir.push_back(make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_quad(rect_x, rect_y, 20*256, 10*256, rect_x, rect_y,
                                0, 32'h11223344, 0, 0, 16384, 16384));
        dir.push_back(make_quad(rect_x, rect_y, 20*256, 10*256, rect_x, rect_y,
                                16384, 32'h55667788, 100, 200, 300, 400));
        dir.push_back(make_quad(rect_x, rect_y, 20*256, 10*256, rect_x, rect_y,
                                32768, 32'h99aabbcc, -100, -200, -300, -400));
        dir.push_back(make_quad(rect_x, rect_y, 20*256, 10*256, rect_x, rect_y,
                                49152, 32'hddeeff00, 0, 0, 0, 0));
        dir.push_back(make_quad(rect_x, rect_y, 20*256, 10*256, rect_x, rect_y,
                                65535, 32'hffffffff, 1, 1, 1, 1));
        dir.push_back(make_quad(rect_x, rect_y, 20*256, 10*256, rect_x, rect_y,
                                1, 32'h0, 0, 0, 0, 0));
        dir.push_back(make_quad(rect_x, rect_y, 20*256, 10*256, rect_x, rect_y,
                                8192, 32'h12345678, 0, 0, 0, 0));
        // pivot away from the center
        dir.push_back(make_quad(rect_x, rect_y, 30*256, 5*256, -rect_x, 0,
                                8192, 32'hcafe0001, 0, 0, 0, 0));
        dir.push_back(make_quad(-rect_x, -rect_y, 7*256, 3*256, 0, 0,
                                40000, 32'hcafe0002, 0, 0, 0, 0));
        // degenerate rectangle
        dir.push_back(make_quad(1234, -5678, 0, 0, 0, 0,
                                12345, 32'hcafe0003, 0, 0, 0, 0));
        // coordinate saturation on both ends
        dir.push_back(make_quad(cmax, cmax, hmax, hmax, 0, 0,
                                0, 32'ha5a5a5a5, 0, 0, 0, 0));
        dir.push_back(make_quad(cmin, cmin, hmax, hmax, 0, 0,
                                0, 32'h5a5a5a5a, 0, 0, 0, 0));
        dir.push_back(make_quad(cmax, cmax, hmax, hmax, cmin, cmin,
                                32768, 32'h0f0f0f0f, 0, 0, 0, 0));
        dir.push_back(make_quad(cmin, cmax, hmax, hmax, cmax, cmin,
                                8192, 32'hf0f0f0f0, 0, 0, 0, 0));
        dir.push_back(make_quad(cmax, cmin, hmax, 0, cmax, cmin,
                                24576, 32'h00ff00ff, 0, 0, 0, 0));
        // texture overflow both ways
        dir.push_back(make_quad(0, 0, 256, 256, 0, 0, 0, 32'h1,
                                32767, 32767, 32767, 32767));
        dir.push_back(make_quad(0, 0, 256, 256, 0, 0, 0, 32'h2,
                                -32768, -32768, -32768, -32768));
        dir.push_back(make_quad(0, 0, 256, 256, 0, 0, 0, 32'h3,
                                32767, -32768, -32768, 32767));
        // every field all ones
        dir.push_back(make_quad(-1, -1, hmax, hmax, -1, -1, 65535, 32'hffffffff,
                                -1, -1, -1, -1));

        foreach (dir[i]) send_quad(dir[i]);

        for (int n = 0; n < RANDOM_QUADS; n++) begin
            if (n == RANDOM_QUADS - CALM_QUADS) calm <= 1'b1;
            send_quad(random_quad());
        end
        s_axis_tvalid <= 1'b0;

        // drain, the watchdog bounds the wait
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* files.f */
src/qcr_pkg.sv
src/qcr_cordic_cell.sv
src/qcr_corner_seq.sv
src/qcr_corner_math.sv
src/quad_corner_rotator.sv
tb/tb.sv
